// ----- rtl/lgst_pkg.sv -----
// lgst_pkg: shared types, codes and constants of the light-gate speed timer
// used by lgst_ctrl, lgst_dp and light_gate_speed_timer_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lgst_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int NOW_W         = 32;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int ELAPSED_W     = 16;
	localparam int SPEED_W       = 24;
	localparam int STATUS_W      = 2;
	localparam int EVENT_W       = 3;
	localparam int OUT_W         = 48;
	// distance_mm * 360 fits in 25 bits
	localparam int DIVIDEND_W    = 25;
	localparam int DIV_STEPS     = DIVIDEND_W;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

	localparam logic [CFG_W-1:0] LOCKOUT_RST  = 16'd300;
	localparam logic [CFG_W-1:0] TIMEOUT_RST  = 16'd10000;
	localparam logic [CFG_W-1:0] MIN_TIME_RST = 16'd50;
	localparam logic [CFG_W-1:0] DISTANCE_RST = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENERGY_MODE = 3'd0,
		REG_LOCKOUT     = 3'd1,
		REG_TIMEOUT     = 3'd2,
		REG_MIN_TIME    = 3'd3,
		REG_DISTANCE    = 3'd4
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_WAITING = 2'd0,
		ST_TIMING  = 2'd1,
		ST_RESULT  = 2'd2
	} status_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE    = 3'd0,
		EV_START   = 3'd1,
		EV_STOP    = 3'd2,
		EV_SHORT   = 3'd3,
		EV_TIMEOUT = 3'd4,
		EV_LOCKED  = 3'd5
	} event_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic eval;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/lgst_ctrl.sv -----
// lgst_ctrl: sequencing state machine of the light-gate speed timer
// depends on lgst_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module lgst_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire                m_tready,
	input  lgst_pkg::dp_stat_t stat,
	output lgst_pkg::dp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;
	logic   s_tready_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign s_tready = s_tready_q;
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && s_tvalid && s_tready_q;
		cmd.eval     = (state_q == S_EVAL);
		cmd.div_step = (state_q == S_DIV);
		cmd.load_out = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			s_tready_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			// a new result beat replaces the one taken in the same cycle
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready_q) begin
						s_tready_q <= 1'b0;
						state_q    <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= stat.need_div ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (stat.div_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						s_tready_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lgst_dp.sv -----
// lgst_dp: registers, timing state, decision logic and serial speed divider
// depends on lgst_pkg; driven by lgst_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module lgst_dp #(
	parameter int TIME_BITS = lgst_pkg::TIME_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [lgst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [lgst_pkg::CFG_W-1:0]          cfg_wdata,
	input  wire                                 in_command,
	input  wire  [lgst_pkg::NOW_W-1:0]          in_now,
	input  lgst_pkg::dp_cmd_t                   cmd,
	output lgst_pkg::dp_stat_t                  stat,
	output logic [lgst_pkg::OUT_W-1:0]          out_data
);

	localparam int EW = lgst_pkg::ELAPSED_W;
	localparam int DW = lgst_pkg::DIVIDEND_W;

	// configuration
	logic                      energy_q;
	logic [lgst_pkg::CFG_W-1:0] lockout_q, timeout_q, min_time_q, distance_q;

	// timing state
	logic                 timing_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] last_q;

	// captured beat
	logic                       command_q;
	logic [lgst_pkg::NOW_W-1:0] now_q;

	// result fields
	lgst_pkg::status_t res_status_q;
	lgst_pkg::event_t  res_event_q;
	logic [EW-1:0]     res_elapsed_q;
	logic              res_div_q;

	// divider
	logic [DW-1:0]          quo_q;
	logic [EW:0]            rem_q;
	logic [EW-1:0]          den_q;
	logic [lgst_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [EW:0]            trial;
	logic                   trial_ok;

	logic [TIME_BITS+lgst_pkg::NOW_W-1:0] now_ext;
	logic [TIME_BITS-1:0]    now_t;
	logic [TIME_BITS-1:0]    d_start, d_last;
	logic [TIME_BITS+EW-1:0] d_start_ext;
	logic [EW-1:0]           el;
	logic                    locked;

	lgst_pkg::status_t nx_status;
	lgst_pkg::event_t  nx_event;
	logic [EW-1:0]     nx_elapsed;
	logic              nx_div, nx_timing, upd_start, upd_last;
	logic [DW-1:0]     dividend;
	logic [lgst_pkg::SPEED_W-1:0] speed;

	assign now_ext     = {{TIME_BITS{1'b0}}, now_q};
	assign now_t       = now_ext[TIME_BITS-1:0];
	assign d_start     = now_t - start_q;
	assign d_last      = now_t - last_q;
	assign d_start_ext = {{EW{1'b0}}, d_start};
	assign el          = !timing_q ? '0 :
	                     (|d_start_ext[TIME_BITS+EW-1:EW]) ? {EW{1'b1}} : d_start[EW-1:0];
	assign locked      = (d_last <= TIME_BITS'(lockout_q));

	// distance * 360 as shifted adds
	assign dividend = (DW'(distance_q) << 8) + (DW'(distance_q) << 6)
	                + (DW'(distance_q) << 5) + (DW'(distance_q) << 3);

	always_comb begin
		nx_status  = lgst_pkg::ST_WAITING;
		nx_event   = lgst_pkg::EV_NONE;
		nx_elapsed = '0;
		nx_div     = 1'b0;
		nx_timing  = timing_q;
		upd_start  = 1'b0;
		upd_last   = 1'b0;
		if (command_q) begin
			if (locked) begin
				nx_status  = timing_q ? lgst_pkg::ST_TIMING : lgst_pkg::ST_WAITING;
				nx_event   = lgst_pkg::EV_LOCKED;
				nx_elapsed = el;
			end else begin
				upd_last = 1'b1;
				if (energy_q) begin
					nx_timing = 1'b0;
					nx_status = lgst_pkg::ST_RESULT;
					nx_event  = lgst_pkg::EV_STOP;
				end else if (!timing_q) begin
					nx_timing = 1'b1;
					upd_start = 1'b1;
					nx_status = lgst_pkg::ST_TIMING;
					nx_event  = lgst_pkg::EV_START;
				end else begin
					nx_timing  = 1'b0;
					nx_elapsed = el;
					if (el > min_time_q) begin
						nx_status = lgst_pkg::ST_RESULT;
						nx_event  = lgst_pkg::EV_STOP;
						nx_div    = 1'b1;
					end else begin
						nx_event  = lgst_pkg::EV_SHORT;
					end
				end
			end
		end else if (energy_q) begin
			if (timing_q) begin
				nx_timing = 1'b0;
				nx_status = lgst_pkg::ST_RESULT;
				nx_event  = lgst_pkg::EV_STOP;
			end
		end else if (timing_q) begin
			nx_elapsed = el;
			if (el > timeout_q) begin
				nx_timing = 1'b0;
				nx_event  = lgst_pkg::EV_TIMEOUT;
			end else begin
				nx_status = lgst_pkg::ST_TIMING;
			end
		end
	end

	assign stat.need_div = nx_div;
	assign stat.div_last = (cnt_q == '0);

	assign trial    = {rem_q[EW-1:0], quo_q[DW-1]} - {1'b0, den_q};
	assign trial_ok = ({rem_q[EW-1:0], quo_q[DW-1]} >= {1'b0, den_q});

	assign speed = (|quo_q[DW-1:lgst_pkg::SPEED_W]) ? {lgst_pkg::SPEED_W{1'b1}}
	             : quo_q[lgst_pkg::SPEED_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q   <= 1'b0;
			lockout_q  <= lgst_pkg::LOCKOUT_RST;
			timeout_q  <= lgst_pkg::TIMEOUT_RST;
			min_time_q <= lgst_pkg::MIN_TIME_RST;
			distance_q <= lgst_pkg::DISTANCE_RST;
			timing_q   <= 1'b0;
			start_q    <= '0;
			last_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lgst_pkg::REG_ENERGY_MODE: energy_q   <= cfg_wdata[0];
					lgst_pkg::REG_LOCKOUT:     lockout_q  <= cfg_wdata;
					lgst_pkg::REG_TIMEOUT:     timeout_q  <= cfg_wdata;
					lgst_pkg::REG_MIN_TIME:    min_time_q <= cfg_wdata;
					lgst_pkg::REG_DISTANCE:    distance_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.eval) begin
				timing_q <= nx_timing;
				if (upd_start) begin
					start_q <= now_t;
				end
				if (upd_last) begin
					last_q <= now_t;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			command_q <= in_command;
			now_q     <= in_now;
		end
		if (cmd.eval) begin
			res_status_q  <= nx_status;
			res_event_q   <= nx_event;
			res_elapsed_q <= nx_elapsed;
			res_div_q     <= nx_div;
			quo_q         <= dividend;
			rem_q         <= '0;
			den_q         <= el;
			cnt_q         <= lgst_pkg::DIV_CNT_W'(lgst_pkg::DIV_STEPS - 1);
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[DW-2:0], trial_ok};
			rem_q <= trial_ok ? trial : {rem_q[EW-1:0], quo_q[DW-1]};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.load_out) begin
			out_data <= {3'b000, (res_div_q ? speed : {lgst_pkg::SPEED_W{1'b0}}),
			             res_elapsed_q, res_event_q, res_status_q};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/light_gate_speed_timer_top.sv -----
// light_gate_speed_timer_top: top level of the light-gate speed timer
// instantiates lgst_ctrl and lgst_dp; types and constants from lgst_pkg
//
// usage
//  - input beats: s_tuser is the command (0 poll, 1 sensor rising edge),
//    s_tdata the 32-bit millisecond timestamp of the beat
//  - every input beat yields exactly one output beat on m_tdata
//  - configuration: cfg_we writes cfg_wdata into register cfg_index
//    (0 energy mode, 1 lockout, 2 timeout, 3 min time, 4 distance);
//    write only while the block is idle, unknown indexes are ignored
//  - each beat is captured, evaluated and loaded into the output register; a valid
//    stop edge also runs the 25-step serial speed divider before the load
//  - s_tready stays low until the result is loaded, so a new beat is not
//    taken before the last one is through; the divider yields one bit per cycle
//  - reset clears the timing state and loads the register defaults;
//    s_tready is high right after reset
//  - when the receiver stalls, the result holds in the output register and
//    the next input beat is still taken; it waits in its final step until
//    the output register frees up
`timescale 1ns / 1ps
`default_nettype none

module light_gate_speed_timer_top #(
	parameter int TIME_BITS = lgst_pkg::TIME_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// configuration write port
	input  wire                            cfg_we,
	input  wire  [lgst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [lgst_pkg::CFG_W-1:0]     cfg_wdata,
	// input stream
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire  [lgst_pkg::NOW_W-1:0]     s_tdata,  // [31:0] now_ms
	input  wire                            s_tuser,  // [0] command
	// result stream
	output logic                           m_tvalid,
	input  wire                            m_tready,
	// [1:0] status, [4:2] event_res, [20:5] elapsed_ms,
	// [44:21] speed_centi_kmh, [47:45] zero
	output logic [lgst_pkg::OUT_W-1:0]     m_tdata
);

	lgst_pkg::dp_cmd_t  cmd;
	lgst_pkg::dp_stat_t stat;

	// sequencer: handshakes and step order
	lgst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// registers, timing state, decisions and speed divider
	lgst_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_command (s_tuser),
		.in_now     (s_tdata),
		.cmd        (cmd),
		.stat       (stat),
		.out_data   (m_tdata)
	);

endmodule

`default_nettype wire

// ----- tb/light_gate_speed_timer_top_tb.sv -----
// light_gate_speed_timer_top_tb: self-checking bench for the light-gate speed timer
// needs lgst_pkg and light_gate_speed_timer_top; predicts every result beat itself
`timescale 1ns / 1ps

module light_gate_speed_timer_top_tb;
	import lgst_pkg::*;

	// run control
	localparam int unsigned RUN_LIMIT     = 300000;  // cycles before giving up
	localparam int unsigned DRAIN_CYCLES  = 32;      // margin past the longest path, through the divider
	localparam int unsigned HOLD_CYCLES   = 300;     // long receiver stall
	localparam int unsigned RANDOM_BEATS  = 400;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;  // unmapped indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic CMD_POLL = 1'b0;
	localparam logic CMD_EDGE = 1'b1;

	// one result beat, same bit order as m_tdata[44:0]
	typedef struct packed {
		logic [SPEED_W-1:0]   speed;
		logic [ELAPSED_W-1:0] elapsed;
		event_t               ev;
		status_t              status;
	} gate_result_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [NOW_W-1:0]     s_tdata   = '0;  // [31:0] now_ms
	logic                 s_tuser   = 1'b0;  // [0] command
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	// [1:0] status, [4:2] event_res, [20:5] elapsed_ms, [44:21] speed_centi_kmh
	logic [OUT_W-1:0]     m_tdata;

	light_gate_speed_timer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// shadow copy of the registers
	logic             energy_q;
	logic [CFG_W-1:0] lockout_q;
	logic [CFG_W-1:0] timeout_q;
	logic [CFG_W-1:0] min_time_q;
	logic [CFG_W-1:0] distance_q;

	// shadow copy of the timing state
	logic             gate_timing;
	logic [NOW_W-1:0] gate_start_ms;
	logic [NOW_W-1:0] gate_last_edge_ms;

	gate_result_t     pending_results[$];
	int unsigned      mismatches  = 0;
	int unsigned      beats_sent  = 0;
	int unsigned      cycle_cnt   = 0;
	logic [NOW_W-1:0] t_ms;

	// idling controls shared by the sender, the receiver and the tests
	bit no_idle     = 1'b0;  // both sides run flat out
	bit sender_fast = 1'b0;  // sender offers back to back
	bit hold_req    = 1'b0;  // receiver takes one long stall

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// predictor: state after reset, register writes, one beat in
	// ---------------------------------------------------------------
	task automatic timer_reset_state;
		energy_q          = 1'b0;
		lockout_q         = LOCKOUT_RST;
		timeout_q         = TIMEOUT_RST;
		min_time_q        = MIN_TIME_RST;
		distance_q        = DISTANCE_RST;
		gate_timing       = 1'b0;
		gate_start_ms     = '0;
		gate_last_edge_ms = '0;
	endtask

	function automatic gate_result_t timer_predict(input logic cmd, input logic [NOW_W-1:0] now);
		gate_result_t         r;
		logic [NOW_W-1:0]     run_ms;
		logic [ELAPSED_W-1:0] el;
		logic [31:0]          quot;
		r      = '0;
		run_ms = now - gate_start_ms;
		// elapsed saturates at 16 bits, zero when nothing is being timed
		if (!gate_timing)
			el = '0;
		else if (run_ms > 32'd65535)
			el = 16'hFFFF;
		else
			el = run_ms[ELAPSED_W-1:0];

		if (cmd == CMD_EDGE) begin
			if (NOW_W'(now - gate_last_edge_ms) <= {16'd0, lockout_q}) begin
				// locked-out edge leaves the state alone
				r.ev      = EV_LOCKED;
				r.elapsed = el;
				if (gate_timing)
					r.status = ST_TIMING;
				else
					r.status = ST_WAITING;
			end else begin
				gate_last_edge_ms = now;
				if (energy_q) begin
					gate_timing = 1'b0;
					r.status    = ST_RESULT;
					r.ev        = EV_STOP;
				end else if (!gate_timing) begin
					gate_timing   = 1'b1;
					gate_start_ms = now;
					r.status      = ST_TIMING;
					r.ev          = EV_START;
				end else begin
					// stop edge, even when past the timeout without a poll
					gate_timing = 1'b0;
					r.elapsed   = el;
					if (el > min_time_q) begin
						quot     = ({16'd0, distance_q} * 32'd360) / {16'd0, el};
						r.speed  = (quot > 32'hFFFFFF) ? 24'hFFFFFF : quot[SPEED_W-1:0];
						r.status = ST_RESULT;
						r.ev     = EV_STOP;
					end else begin
						r.status = ST_WAITING;
						r.ev     = EV_SHORT;
					end
				end
			end
		end else if (energy_q) begin
			// poll in energy mode flushes leftover timing as a result
			if (gate_timing) begin
				gate_timing = 1'b0;
				r.status    = ST_RESULT;
				r.ev        = EV_STOP;
			end
		end else if (gate_timing) begin
			r.elapsed = el;
			if (el > timeout_q) begin
				gate_timing = 1'b0;
				r.ev        = EV_TIMEOUT;
			end else begin
				r.status = ST_TIMING;
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// register write, only called while the block is idle
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENERGY_MODE: energy_q   = val[0];
			REG_LOCKOUT:     lockout_q  = val;
			REG_TIMEOUT:     timeout_q  = val;
			REG_MIN_TIME:    min_time_q = val;
			REG_DISTANCE:    distance_q = val;
			default: ;
		endcase
		// spacer so back-to-back writes never stack two updates of cfg_we
		@(posedge clk);
	endtask

	// offer one beat after a random gap; valid stays high on return
	task automatic send_beat(input logic cmd, input logic [NOW_W-1:0] now);
		int unsigned gap;
		gap = (sender_fast || no_idle) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= now;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(timer_predict(cmd, now));
		beats_sent++;
	endtask

	// sender stops and waits for every outstanding result
	task automatic wait_results_drained;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver: random stall per result, plus one long hold-off on request
	initial begin
		int unsigned w;
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				w = no_idle ? 0 : $urandom_range(0, 13);
				if (w > 0) begin
					m_tready <= 1'b0;
					repeat (w) @(posedge clk);
				end
				m_tready <= 1'b1;
				do @(posedge clk); while (!m_tvalid);
			end
		end
	end

	// result checker: every accepted result against the oldest prediction
	always @(posedge clk) begin : result_check
		gate_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat expected none actual %h",
					$time, m_tdata);
				mismatches++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata[1:0] !== exp_r.status) begin
					$display("%0t: status mismatch expected %0d actual %0d",
						$time, exp_r.status, m_tdata[1:0]);
					mismatches++;
				end
				if (m_tdata[4:2] !== exp_r.ev) begin
					$display("%0t: event mismatch expected %0d actual %0d",
						$time, exp_r.ev, m_tdata[4:2]);
					mismatches++;
				end
				if (m_tdata[20:5] !== exp_r.elapsed) begin
					$display("%0t: elapsed mismatch expected %0d actual %0d",
						$time, exp_r.elapsed, m_tdata[20:5]);
					mismatches++;
				end
				if (m_tdata[44:21] !== exp_r.speed) begin
					$display("%0t: speed mismatch expected %0d actual %0d",
						$time, exp_r.speed, m_tdata[44:21]);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_cnt < RUN_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset defaults: lockout window edges, start, running poll, stop, timeout
	task automatic test_lockout_and_timeout;
		send_beat(CMD_POLL, 32'd0);          // waiting poll
		send_beat(CMD_EDGE, 32'd0);          // inside lockout of the reset edge time
		send_beat(CMD_EDGE, 32'd301);        // start
		send_beat(CMD_POLL, 32'd500);        // running elapsed
		send_beat(CMD_EDGE, 32'd550);        // locked out while timing
		send_beat(CMD_EDGE, 32'd602);        // stop with speed
		send_beat(CMD_EDGE, 32'd902);        // exactly lockout apart, still locked
		send_beat(CMD_EDGE, 32'd903);        // start
		send_beat(CMD_POLL, 32'd10903);      // elapsed equals timeout, keeps timing
		send_beat(CMD_POLL, 32'd10904);      // one past timeout
		wait_results_drained();
	endtask

	// min-time boundary, too-short stop, zero lockout
	task automatic test_min_time_boundary;
		cfg_write(REG_LOCKOUT, 16'd0);
		cfg_write(REG_MIN_TIME, 16'd50);
		t_ms = 32'd100000;
		send_beat(CMD_EDGE, t_ms);
		send_beat(CMD_EDGE, t_ms + 32'd50);  // elapsed equals min time: too short
		send_beat(CMD_EDGE, t_ms + 32'd50);  // zero gap, locked even at lockout 0
		send_beat(CMD_EDGE, t_ms + 32'd100);
		send_beat(CMD_EDGE, t_ms + 32'd151); // one past min time: valid
		wait_results_drained();
	endtask

	// stop past timeout without poll, timestamp wrap, elapsed saturation
	task automatic test_late_stop_and_wrap;
		t_ms = 32'd200000;
		send_beat(CMD_EDGE, t_ms);
		send_beat(CMD_EDGE, t_ms + 32'd20000);
		send_beat(CMD_EDGE, 32'hFFFF_FF00);
		send_beat(CMD_EDGE, 32'h0000_0100);
		send_beat(CMD_EDGE, 32'h0001_0000);
		send_beat(CMD_EDGE, 32'h0001_0000 + 32'd100000);
		wait_results_drained();
	endtask

	// speed saturation, zero distance, zero timeout
	task automatic test_register_extremes;
		cfg_write(REG_DISTANCE, 16'hFFFF);
		cfg_write(REG_MIN_TIME, 16'd0);
		t_ms = 32'h8000_0000;
		send_beat(CMD_EDGE, t_ms);
		send_beat(CMD_EDGE, t_ms + 32'd1);
		wait_results_drained();
		cfg_write(REG_DISTANCE, 16'd0);
		cfg_write(REG_TIMEOUT, 16'd0);
		send_beat(CMD_EDGE, t_ms + 32'd10);
		send_beat(CMD_EDGE, t_ms + 32'd17);  // stop, speed 0
		send_beat(CMD_EDGE, t_ms + 32'd20);
		send_beat(CMD_POLL, t_ms + 32'd20);  // zero elapsed, not past 0
		send_beat(CMD_POLL, t_ms + 32'd21);  // timeout
		wait_results_drained();
	endtask

	// energy mode with leftover timing, masked writes, spare indexes, max lockout
	task automatic test_energy_mode;
		cfg_write(REG_DISTANCE, 16'd1000);
		cfg_write(REG_TIMEOUT, 16'd10000);
		t_ms = 32'h4000_0000;
		send_beat(CMD_EDGE, t_ms);           // leaves timing running
		wait_results_drained();
		cfg_write(REG_ENERGY_MODE, 16'hFFFF);
		send_beat(CMD_POLL, t_ms + 32'd5);   // flushes the leftover timing
		send_beat(CMD_POLL, t_ms + 32'd6);
		send_beat(CMD_EDGE, t_ms + 32'd7);
		send_beat(CMD_EDGE, t_ms + 32'd7);   // locked in energy mode
		wait_results_drained();
		cfg_write(REG_ENERGY_MODE, 16'hFFFE); // only bit 0 counts
		cfg_write(REG_SPARE_LO, 16'hFFFF);
		cfg_write(REG_SPARE_HI, 16'hFFFF);
		cfg_write(REG_LOCKOUT, 16'hFFFF);
		send_beat(CMD_EDGE, t_ms + 32'd7 + 32'd65535);
		send_beat(CMD_EDGE, t_ms + 32'd7 + 32'd65536);
		wait_results_drained();
	endtask

	// receiver holds off while the sender keeps offering, then the sender pauses
	task automatic test_backpressure;
		cfg_write(REG_LOCKOUT, 16'd20);
		cfg_write(REG_MIN_TIME, 16'd2);
		hold_req    = 1'b1;
		sender_fast = 1'b1;
		t_ms        = 32'h0100_0000;
		repeat (12) begin
			t_ms += 32'd25;
			send_beat($urandom_range(0, 3) != 0, t_ms);
		end
		sender_fast = 1'b0;
		wait_results_drained();
	endtask

	// one start/stop run with polls in between, stop sometimes aimed at a boundary
	task automatic send_timed_run;
		logic [NOW_W-1:0] t_start;
		logic [NOW_W-1:0] span;
		t_ms    = t_ms + lockout_q + 32'd1 + $urandom_range(0, 40);
		t_start = t_ms;
		send_beat(CMD_EDGE, t_start);
		case ($urandom_range(0, 4))
			0: span = min_time_q + $urandom_range(0, 3) - 32'd1;
			1: span = timeout_q + $urandom_range(0, 3) - 32'd1;
			2: span = $urandom_range(1, 3000);
			3: span = $urandom_range(0, 200000);
			default: span = lockout_q + 32'd1 + $urandom_range(0, 500);
		endcase
		repeat ($urandom_range(0, 3))
			send_beat(CMD_POLL, t_start + $urandom_range(0, span));
		// poll right at the timeout edge now and then
		if ($urandom_range(0, 3) == 0)
			send_beat(CMD_POLL, t_start + timeout_q + $urandom_range(0, 1));
		t_ms = t_start + span;
		send_beat(CMD_EDGE, t_ms);
	endtask

	// loose beat: random command, any distance in time
	task automatic send_noise_beat;
		case ($urandom_range(0, 3))
			0: t_ms = t_ms + $urandom_range(0, lockout_q);
			1: t_ms = $urandom();
			2: t_ms = t_ms + $urandom_range(0, 70000);
			default: ;
		endcase
		send_beat($urandom_range(0, 1), t_ms);
	endtask

	// random phases, new settings each time, mostly well-formed runs
	task automatic test_random_phases;
		int unsigned phase_end;
		t_ms = $urandom();
		while (beats_sent < RANDOM_BEATS) begin
			wait_results_drained();
			case ($urandom_range(0, 5))
				0: begin
					cfg_write(REG_ENERGY_MODE, 16'd0);
					cfg_write(REG_LOCKOUT, 16'd0);
					cfg_write(REG_TIMEOUT, 16'd1);
					cfg_write(REG_MIN_TIME, 16'd0);
					cfg_write(REG_DISTANCE, 16'd1);
				end
				1: begin
					cfg_write(REG_ENERGY_MODE, 16'd0);
					cfg_write(REG_LOCKOUT, 16'hFFFF);
					cfg_write(REG_TIMEOUT, 16'hFFFF);
					cfg_write(REG_MIN_TIME, 16'hFFFF);
					cfg_write(REG_DISTANCE, 16'hFFFF);
				end
				default: begin
					cfg_write(REG_ENERGY_MODE, ($urandom_range(0, 4) == 0) ? 16'd1 : 16'd0);
					cfg_write(REG_LOCKOUT, ($urandom_range(0, 3) == 0) ?
						16'($urandom()) : 16'($urandom_range(0, 400)));
					cfg_write(REG_TIMEOUT, ($urandom_range(0, 3) == 0) ?
						16'($urandom()) : 16'($urandom_range(1, 20000)));
					cfg_write(REG_MIN_TIME, ($urandom_range(0, 3) == 0) ?
						16'($urandom()) : 16'($urandom_range(0, 200)));
					cfg_write(REG_DISTANCE, 16'($urandom()));
				end
			endcase
			// some phases run with no idling at all
			no_idle   = ($urandom_range(0, 4) == 0);
			phase_end = beats_sent + $urandom_range(40, 60);
			while (beats_sent < phase_end) begin
				if ($urandom_range(0, 9) < 7)
					send_timed_run();
				else
					send_noise_beat();
			end
			no_idle = 1'b0;
		end
		wait_results_drained();
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		timer_reset_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lockout_and_timeout();
		test_min_time_boundary();
		test_late_stop_and_wrap();
		test_register_extremes();
		test_energy_mode();
		test_backpressure();
		test_random_phases();

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lgst_pkg.sv
rtl/lgst_ctrl.sv
rtl/lgst_dp.sv
rtl/light_gate_speed_timer_top.sv
tb/light_gate_speed_timer_top_tb.sv
